/* rtl/byte_ring_fifo_with_peek_top_assert.svh */
// Assertion macros for the byte ring FIFO top level.
`ifndef BYTE_RING_FIFO_WITH_PEEK_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BFP_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("bfp assertion failed");

// Next-cycle implication.
`define BFP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("bfp assertion failed");

`endif

/* rtl/bfp_pkg.sv */
`timescale 1ns / 1ps
package bfp_pkg;

   // Command codes of the input item.
   typedef enum logic [1:0] {
      CMD_PUT  = 2'd0,
      CMD_GET  = 2'd1,
      CMD_PEEK = 2'd2,
      CMD_LEN  = 2'd3
   } cmd_code_type;

   localparam logic [3:0] CAP_LOG2_RESET = 4'd10;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [6:0] request_count;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [6:0]  granted;
      logic [10:0] fill_level;
      logic        last;
   } rsp_type;

   // Classified command handed from front to back.
   typedef struct packed {
      logic       is_put;
      logic       is_read;   // get or peek
      logic       consume;   // get: advance read pointer
      logic [7:0] data;
      logic [6:0] count;     // already clamped to the burst limit
   } cmd_type;

endpackage

/* rtl/byte_ring_fifo_with_peek_top.sv */
`timescale 1ns / 1ps
// Path of an accepted item to its first result: command queue, back stage, result queue.
// Throughput: put and length query, one item per cycle; get or peek, one byte per cycle
// from the single read port of the byte store; both only while the result queue has room.
// Reset (synchronous, active high): pointers zero, capacity exponent 10, both queues empty.
// The byte store is not cleared; its entries are read only after being written.
module byte_ring_fifo_with_peek_top #(
   parameter int DEPTH_LOG2 = 10,
   parameter int MAX_BURST  = 64
) (
   input  logic             clock,
   input  logic             reset,
   // input item channel
   input  logic             req_push,
   output logic             req_full,
   input  bfp_pkg::req_type req_item,
   // result item channel
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bfp_pkg::rsp_type rsp_item,
   // capacity register
   input  logic             csr_we,
   input  logic [3:0]       csr_wdata
);
`include "byte_ring_fifo_with_peek_top_assert.svh"

   // front to back: classified command item
   logic             cmd_valid;
   logic             cmd_pop;
   bfp_pkg::cmd_type cmd;

   // back to result queue
   logic             rsp_push;
   logic             rsp_room;
   logic             rsp_q_full;
   bfp_pkg::rsp_type back_item;

   // Front: two-item queue; decodes the command and clamps the burst.
   bfp_front #(
      .MAX_BURST(MAX_BURST)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cmd_pop  (cmd_pop),
      .cmd_valid(cmd_valid),
      .cmd      (cmd)
   );

   // Back: owns pointers, capacity and the byte store. Issues a result only when
   // the result queue has two free slots, covering the registered read stage.
   bfp_back #(
      .DEPTH_LOG2(DEPTH_LOG2)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_room (rsp_room),
      .rsp_push (rsp_push),
      .rsp_item (back_item)
   );

   // Result queue, four items deep.
   bfp_fifo #(
      .WIDTH ($bits(bfp_pkg::rsp_type)),
      .ADDR_W(2)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (rsp_push),
      .wr_data(back_item),
      .full   (rsp_q_full),
      .rd_en  (rsp_pop),
      .rd_data(rsp_item),
      .empty  (rsp_empty),
      .room2  (rsp_room)
   );

   // credit scheme must never overrun the result queue
   `BFP_ASSERT_IMPL(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_q_full)
   // back only pops a command that is there
   `BFP_ASSERT_IMPL(a_cmd_pop_valid, clock, reset, cmd_pop, cmd_valid)
   // a zero-grant result is always the only result of its item
   `BFP_ASSERT_IMPL(a_zero_grant_last, clock, reset,
                    !rsp_empty && (rsp_item.granted == 7'd0), rsp_item.last)
   // a push leaves the result queue non-empty in the next cycle
   `BFP_ASSERT_NEXT(a_push_fills, clock, reset, rsp_push, !rsp_empty)

endmodule

/* rtl/bfp_fifo.sv */
`timescale 1ns / 1ps
module bfp_fifo #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             room2
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [ADDR_W:0]  wr_ptr_ff, rd_ptr_ff;
   logic [ADDR_W:0]  count;

   assign count   = wr_ptr_ff - rd_ptr_ff;
   assign full    = (count == (ADDR_W + 1)'(DEPTH));
   assign empty   = (count == '0);
   assign room2   = (count <= (ADDR_W + 1)'(DEPTH - 2));
   assign rd_data = slot_ff[rd_ptr_ff[ADDR_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (wr_en && !full) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         slot_ff[wr_ptr_ff[ADDR_W-1:0]] <= wr_data;
      end
   end

endmodule

/* rtl/bfp_front.sv */
`timescale 1ns / 1ps
module bfp_front #(
   parameter int MAX_BURST = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bfp_pkg::req_type  req_item,
   input  logic              cmd_pop,
   output logic              cmd_valid,
   output bfp_pkg::cmd_type  cmd
);
   bfp_pkg::cmd_type     cls;
   bfp_pkg::cmd_code_type code;
   logic                 cmd_empty;
   logic [6:0]           burst_max;

   assign code      = bfp_pkg::cmd_code_type'(req_item.command);
   assign burst_max = 7'(MAX_BURST);

   always_comb begin
      cls.is_put  = 1'b0;
      cls.is_read = 1'b0;
      cls.consume = 1'b0;
      cls.data    = req_item.data_byte;
      cls.count   = (req_item.request_count > burst_max) ? burst_max
                                                         : req_item.request_count;
      unique case (code)
         bfp_pkg::CMD_PUT:  cls.is_put = 1'b1;
         bfp_pkg::CMD_GET: begin
            cls.is_read = 1'b1;
            cls.consume = 1'b1;
         end
         bfp_pkg::CMD_PEEK: cls.is_read = 1'b1;
         bfp_pkg::CMD_LEN:  cls.is_put = 1'b0;
         default:           cls.is_put = 1'b0;
      endcase
   end

   bfp_fifo #(
      .WIDTH ($bits(bfp_pkg::cmd_type)),
      .ADDR_W(1)
   ) u_cmd_q (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (req_push),
      .wr_data(cls),
      .full   (req_full),
      .rd_en  (cmd_pop),
      .rd_data(cmd),
      .empty  (cmd_empty),
      .room2  ()
   );

   assign cmd_valid = !cmd_empty;

endmodule

/* rtl/bfp_back.sv */
`timescale 1ns / 1ps
module bfp_back #(
   parameter int DEPTH_LOG2 = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata,
   input  logic              cmd_valid,
   input  bfp_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              rsp_room,
   output logic              rsp_push,
   output bfp_pkg::rsp_type  rsp_item
);
   localparam int AW    = DEPTH_LOG2;
   localparam int PW    = DEPTH_LOG2 + 1;
   localparam int XW    = (PW > 11) ? PW : 11;
   localparam int DEPTH = 1 << AW;

   typedef enum logic {ST_IDLE, ST_BURST} state_type;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   state_type   state_ff, state_in;
   logic [3:0]  cap_log2_ff, cap_log2_in;
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in, cur_ff, cur_in;
   logic [6:0]  left_ff, left_in;
   logic [6:0]  n_ff, n_in;
   logic [10:0] after_ff, after_in;
   logic        stg_valid_ff, stg_valid_in;
   logic        stg_mem_ff, stg_mem_in;
   logic        stg_last_ff, stg_last_in;
   logic [6:0]  stg_granted_ff, stg_granted_in;
   logic [10:0] stg_fill_ff, stg_fill_in;

   logic [4:0]    lg;
   logic [XW-1:0] cap_x, fill_x, req_x, n_x, after_x;
   logic [AW-1:0] imask;
   logic [PW-1:0] fill;
   logic          go, room_ok;
   logic          mem_we, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;

   // Capacity above the store depth acts as the full store.
   assign lg      = ({1'b0, cap_log2_ff} > 5'(DEPTH_LOG2)) ? 5'(DEPTH_LOG2)
                                                           : {1'b0, cap_log2_ff};
   assign cap_x   = XW'(1) << lg;
   assign imask   = AW'(cap_x - XW'(1));
   assign fill    = wp_ff - rp_ff;
   assign fill_x  = XW'(fill);
   assign req_x   = XW'(cmd.count);
   assign n_x     = (fill_x < req_x) ? fill_x : req_x;
   assign after_x = cmd.consume ? (fill_x - n_x) : fill_x;
   assign room_ok = fill_x < cap_x;
   assign go      = (state_ff == ST_IDLE) && cmd_valid && rsp_room;
   assign cmd_pop = go;

   assign mem_we  = go && cmd.is_put && room_ok;
   assign wr_addr = wp_ff[AW-1:0] & imask;

   always_comb begin
      state_in       = state_ff;
      cap_log2_in    = cap_log2_ff;
      wp_in          = wp_ff;
      rp_in          = rp_ff;
      cur_in         = cur_ff;
      left_in        = left_ff;
      n_in           = n_ff;
      after_in       = after_ff;
      stg_valid_in   = 1'b0;
      stg_mem_in     = 1'b0;
      stg_last_in    = 1'b1;
      stg_granted_in = '0;
      stg_fill_in    = fill_x[10:0];
      rd_en          = 1'b0;
      rd_addr        = rp_ff[AW-1:0] & imask;

      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               stg_valid_in = 1'b1;
               if (cmd.is_put) begin
                  if (room_ok) begin
                     wp_in          = wp_ff + 1'b1;
                     stg_granted_in = 7'd1;
                     stg_fill_in    = 11'(fill_x + XW'(1));
                  end
               end else if (cmd.is_read && (n_x != '0)) begin
                  // first byte now, the rest one per cycle in the burst state while the result queue has room
                  rd_en          = 1'b1;
                  stg_mem_in     = 1'b1;
                  stg_granted_in = n_x[6:0];
                  stg_fill_in    = after_x[10:0];
                  stg_last_in    = (n_x == XW'(1));
                  n_in           = n_x[6:0];
                  after_in       = after_x[10:0];
                  cur_in         = rp_ff + 1'b1;
                  left_in        = 7'(n_x - XW'(1));
                  if (cmd.consume) begin
                     rp_in = rp_ff + PW'(n_x);
                  end
                  if (n_x != XW'(1)) begin
                     state_in = ST_BURST;
                  end
               end
            end
         end
         ST_BURST: begin
            rd_addr = cur_ff[AW-1:0] & imask;
            if (rsp_room) begin
               rd_en          = 1'b1;
               stg_valid_in   = 1'b1;
               stg_mem_in     = 1'b1;
               stg_granted_in = n_ff;
               stg_fill_in    = after_ff;
               stg_last_in    = (left_ff == 7'd1);
               cur_in         = cur_ff + 1'b1;
               left_in        = left_ff - 7'd1;
               if (left_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // capacity write empties the ring
      if (csr_we) begin
         cap_log2_in = csr_wdata;
         wp_in       = '0;
         rp_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_log2_ff  <= bfp_pkg::CAP_LOG2_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_log2_ff  <= cap_log2_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         stg_valid_ff <= stg_valid_in;
      end
      cur_ff         <= cur_in;
      left_ff        <= left_in;
      n_ff           <= n_in;
      after_ff       <= after_in;
      stg_mem_ff     <= stg_mem_in;
      stg_last_ff    <= stg_last_in;
      stg_granted_ff <= stg_granted_in;
      stg_fill_ff    <= stg_fill_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_push            = stg_valid_ff;
   assign rsp_item.out_byte   = stg_mem_ff ? rd_data_ff : 8'd0;
   assign rsp_item.granted    = stg_granted_ff;
   assign rsp_item.fill_level = stg_fill_ff;
   assign rsp_item.last       = stg_last_ff;

endmodule
